>>> rtl/assert_macros.svh
// assertion helpers for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/lppd_pkg.sv
package lppd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [7:0] TRAILER_FIXED = 8'hff;

  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_CHECK_MODE = 1'b1;

  typedef struct packed {
    logic cap_hunt;
    logic cap_id;
    logic cap_len;
    logic cap_data;
    logic emit_start;
    logic emit_read;
    logic emit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic start_match;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic trailer_good;
    logic emit_last;
  } dp_sts_t;

endpackage

>>> rtl/lppd_ram.sv
module lppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lppd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lppd_regs.sv
module lppd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lppd_pkg::PADDR_W-1:0] paddr,
  input  logic [lppd_pkg::PDATA_W-1:0] pwdata,
  output logic [lppd_pkg::PDATA_W-1:0] prdata,
  output logic [7:0]                   start_byte,
  output logic                         check_mode
);

  logic wr_en;
  logic reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'd0;
      check_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        lppd_pkg::REG_START_BYTE: start_byte <= pwdata[7:0];
        lppd_pkg::REG_CHECK_MODE: check_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lppd_pkg::REG_START_BYTE: prdata = {24'd0, start_byte};
      lppd_pkg::REG_CHECK_MODE: prdata = {31'd0, check_mode};
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/lppd_dp.sv
module lppd_dp #(
  parameter int MAX_PAYLOAD = lppd_pkg::MAX_PAYLOAD_DEF,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        start_byte,
  input  logic              check_mode,
  input  lppd_pkg::dp_cmd_t cmd,
  output lppd_pkg::dp_sts_t sts,
  output logic [7:0]        msg_id,
  output logic [6:0]        payload_len,
  output logic              has_payload,
  output logic [5:0]        payload_index,
  output logic [7:0]        payload_byte,
  output logic              last
);

  logic [7:0] held_msg_id;
  logic [6:0] held_length;
  logic [6:0] byte_count;
  logic [6:0] byte_count_next;
  logic [7:0] running_sum;
  logic [7:0] sum_next;
  logic [5:0] emit_idx;
  logic [7:0] rd_byte;
  logic [7:0] trailer_ref;

  assign byte_count_next = byte_count + 7'd1;
  assign sum_next        = running_sum + rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_msg_id <= 8'd0;
      held_length <= 7'd0;
      byte_count  <= 7'd0;
      running_sum <= 8'd0;
      emit_idx    <= 6'd0;
    end else begin
      if (cmd.cap_hunt) begin
        running_sum <= rx_byte;
      end
      if (cmd.cap_id) begin
        held_msg_id <= rx_byte;
        running_sum <= sum_next;
      end
      if (cmd.cap_len) begin
        held_length <= rx_byte[6:0];
        byte_count  <= 7'd0;
        running_sum <= sum_next;
      end
      if (cmd.cap_data) begin
        byte_count  <= byte_count_next;
        running_sum <= sum_next;
      end
      if (cmd.emit_start) begin
        emit_idx <= 6'd0;
      end else if (cmd.emit_next) begin
        emit_idx <= emit_idx + 6'd1;
      end
    end
  end

  lppd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.cap_data),
    .waddr (byte_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.emit_read),
    .raddr (emit_idx[AW-1:0]),
    .rdata (rd_byte)
  );

  assign trailer_ref = check_mode ? running_sum : lppd_pkg::TRAILER_FIXED;

  assign sts.start_match  = (rx_byte == start_byte);
  assign sts.len_ok       = (rx_byte <= 8'(MAX_PAYLOAD));
  assign sts.len_zero     = (rx_byte == 8'd0);
  assign sts.data_done    = (byte_count_next >= held_length);
  assign sts.trailer_good = (rx_byte == trailer_ref);
  assign sts.emit_last    = last;

  assign msg_id        = held_msg_id;
  assign payload_len   = held_length;
  assign has_payload   = (held_length != 7'd0);
  assign payload_index = emit_idx;
  assign payload_byte  = has_payload ? rd_byte : 8'd0;
  assign last          = !has_payload || ((7'(emit_idx) + 7'd1) == held_length);

endmodule

>>> rtl/lppd_ctrl.sv
module lppd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lppd_pkg::dp_sts_t sts,
  output lppd_pkg::dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_HUNT  = 7'b0000001,
    S_ID    = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_DATA  = 7'b0001000,
    S_TRAIL = 7'b0010000,
    S_READ  = 7'b0100000,
    S_SHOW  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_acc;
  logic   out_acc;

  assign in_ready  = (state == S_HUNT) || (state == S_ID) || (state == S_LEN) ||
                     (state == S_DATA) || (state == S_TRAIL);
  assign out_valid = (state == S_SHOW);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_HUNT: begin
        if (in_acc) begin
          cmd.cap_hunt = 1'b1;
          if (sts.start_match) begin
            state_next = S_ID;
          end
        end
      end
      S_ID: begin
        if (in_acc) begin
          cmd.cap_id = 1'b1;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (in_acc) begin
          if (sts.len_ok) begin
            cmd.cap_len = 1'b1;
            state_next  = sts.len_zero ? S_TRAIL : S_DATA;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_DATA: begin
        if (in_acc) begin
          cmd.cap_data = 1'b1;
          if (sts.data_done) begin
            state_next = S_TRAIL;
          end
        end
      end
      S_TRAIL: begin
        if (in_acc) begin
          if (sts.trailer_good) begin
            cmd.emit_start = 1'b1;
            state_next     = S_READ;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_READ: begin
        cmd.emit_read = 1'b1;
        state_next    = S_SHOW;
      end
      S_SHOW: begin
        if (out_acc) begin
          if (sts.emit_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

endmodule

>>> rtl/length_prefixed_packet_deframer.sv
// Packet deframer: hunts for the start byte, takes id, length (up to MAX_PAYLOAD),
// payload and trailer, one received byte per cycle while framing. A good frame is
// then played out one result per payload byte (one result for an empty frame); each
// result is a read of the payload RAM followed by the output request, which waits
// for out_ready, and no byte is taken until the last result of the frame has been
// accepted. Trailer check: 0xFF when check_mode is 0, else the 8-bit sum of start,
// id, length and payload bytes. Bad frames are dropped without any result.
`include "assert_macros.svh"

module length_prefixed_packet_deframer #(
  parameter int MAX_PAYLOAD = lppd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lppd_pkg::PADDR_W-1:0] paddr,
  input  logic [lppd_pkg::PDATA_W-1:0] pwdata,
  output logic [lppd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   msg_id,
  output logic [6:0]                   payload_len,
  output logic                         has_payload,
  output logic [5:0]                   payload_index,
  output logic [7:0]                   payload_byte,
  output logic                         last
);

  logic [7:0]        start_byte;
  logic              check_mode;
  lppd_pkg::dp_cmd_t cmd;
  lppd_pkg::dp_sts_t sts;

  assign pready = 1'b1;

  lppd_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .start_byte (start_byte),
    .check_mode (check_mode)
  );

  lppd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lppd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .start_byte    (start_byte),
    .check_mode    (check_mode),
    .cmd           (cmd),
    .sts           (sts),
    .msg_id        (msg_id),
    .payload_len   (payload_len),
    .has_payload   (has_payload),
    .payload_index (payload_index),
    .payload_byte  (payload_byte),
    .last          (last)
  );

  `ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid, "receive open during playout")
  `ASSERT_PROP(a_playout_holds, clk, rst, out_valid && out_ready && !last |=> !in_ready, "frame playout cut short")
  `ASSERT_PROP(a_empty_frame, clk, rst, out_valid && !has_payload |-> last && (payload_index == 6'd0), "bad empty frame result")
  `ASSERT_PROP(a_index_range, clk, rst, out_valid && has_payload |-> (7'(payload_index) < payload_len), "payload index past length")

endmodule
